FILE: design/pr3_pkg.sv
// Shared types and constants for the 3x3 pyramid reduce core.
// No dependencies; imported by every pr3 module.
`timescale 1ns / 1ps
`default_nettype none
package pr3_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W       = 8;
	localparam int SUM_W       = 12;
	localparam int OUT_COL_W   = 9;
	localparam int OUT_ROW_W   = 11;
	localparam int OUT_TDATA_W = 32;
	localparam int FRAME_W_W   = 11;
	localparam int FRAME_H_W   = 13;
	localparam int ROW_W       = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam int FRAME_W_RST = 640;
	localparam int FRAME_H_RST = 480;
	localparam int SUM_MAX     = 4080;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// position info of one input word
	typedef struct packed {
		logic                 c_odd;
		logic                 r_odd;
		logic                 col_edge;  // column pair 0: left neighbor clamps
		logic                 row_edge;  // row pair 0: upper neighbor clamps
		logic                 last_col;
		logic                 last_row;
		logic [OUT_COL_W-1:0] out_col;
		logic [OUT_ROW_W-1:0] out_row;
	} tag_t;

endpackage
`default_nettype wire

FILE: design/pyramid_reduce_3x3_core.sv
// 3x3 binomial pyramid reduce: 8-bit raster pixels in, half-size 8.4 results out.
// Stage 1 takes the line-buffer RAM read at accept; the sum goes to the output register.
// One pixel per cycle unless output stalls; RAM write-back as the word leaves stage 1.
// Accepts input while a result waits at the output; stage 1 holds one word.
// Reset (arst_n low, async): counters, window and valids clear, 640x480 geometry.
// Line-buffer RAM is not cleared; each row is written before it is read.
`timescale 1ns / 1ps
`default_nettype none
module pyramid_reduce_3x3_core #(
	parameter int MAX_WIDTH = pr3_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,   // [7:0] pixel
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [pr3_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [11:0] blurred, [20:12] out_col,
	                                                         // [31:21] out_row
	output logic                                  m_tlast,   // frame_done
	input  wire logic                             cfg_we,
	input  wire logic [pr3_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [pr3_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pr3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic             accept;
	tag_t             tag;
	logic [AW-1:0]    addr;
	logic [PIX_W-1:0] older, newer;
	logic             wr_en;
	logic [PIX_W-1:0] wr_older, wr_newer;

	assign accept = s_tvalid && s_tready;

	pr3_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.adv      (accept),
		.tag      (tag),
		.addr     (addr)
	);

	pr3_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (addr),
		.wr_en    (wr_en),
		.wr_older (wr_older),
		.wr_newer (wr_newer),
		.older    (older),
		.newer    (newer)
	);

	pr3_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.tag_i    (tag),
		.px_i     (s_tdata[PIX_W-1:0]),
		.older    (older),
		.newer    (newer),
		.in_ready (s_tready),
		.wr_en    (wr_en),
		.wr_older (wr_older),
		.wr_newer (wr_newer),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: design/pr3_pos.sv
// Frame geometry registers and raster position counters.
// Depends on pr3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pr3_pos #(
	parameter int MAX_WIDTH = pr3_pkg::MAX_WIDTH_DEF,
	localparam int CNT_W = $clog2(MAX_WIDTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pr3_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [pr3_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            adv,
	output pr3_pkg::tag_t                        tag,
	output logic      [CNT_W-1:0]                addr
);
	import pr3_pkg::*;

	logic [FRAME_W_W-1:0] width_q;
	logic [FRAME_H_W-1:0] height_q;
	logic [CNT_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [CNT_W-1:0]     w_last;
	logic [ROW_W-1:0]     h_last;
	logic                 last_col;
	logic                 last_row;
	logic                 cfg_hit;

	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_last = CNT_W'(MAX_WIDTH - 1);
		end else begin
			w_last = CNT_W'(width_q - FRAME_W_W'(1));
		end
		if (height_q == '0) begin
			h_last = '0;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_last = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			h_last = ROW_W'(height_q - FRAME_H_W'(1));
		end
	end

	always_comb begin
		case (cfg_reg_t'(cfg_idx))
			REG_FRAME_WIDTH:  cfg_hit = cfg_we;
			REG_FRAME_HEIGHT: cfg_hit = cfg_we;
			default:          cfg_hit = 1'b0;
		endcase
	end

	assign last_col = (col_q == w_last);
	assign last_row = (row_q == h_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_W_W'(FRAME_W_RST);
			height_q <= FRAME_H_W'(FRAME_H_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_FRAME_WIDTH:  width_q  <= cfg_data[FRAME_W_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[FRAME_H_W-1:0];
				default: ;
			endcase
		end
	end

	// any register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	assign addr = col_q;

	always_comb begin
		tag.c_odd    = col_q[0];
		tag.r_odd    = row_q[0];
		tag.col_edge = ((col_q >> 1) == '0);
		tag.row_edge = ((row_q >> 1) == '0);
		tag.last_col = last_col;
		tag.last_row = last_row;
		tag.out_col  = OUT_COL_W'(col_q >> 1);
		tag.out_row  = OUT_ROW_W'(row_q >> 1);
	end

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last)
		else $error("column counter beyond frame width");
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last)
		else $error("row counter beyond frame height");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (col_q == '0) && (row_q == '0))
		else $error("register write did not restart frame");

endmodule
`default_nettype wire

FILE: design/pr3_linebuf.sv
// Two line buffers packed in one synchronous RAM (older row, newer row).
// Read at accept, write back as the word leaves stage 1, with same-edge forwarding.
// Depends on pr3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pr3_linebuf #(
	parameter int MAX_WIDTH = pr3_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rd_en,
	input  wire logic [AW-1:0]              rd_addr,
	input  wire logic                       wr_en,
	input  wire logic [pr3_pkg::PIX_W-1:0]  wr_older,
	input  wire logic [pr3_pkg::PIX_W-1:0]  wr_newer,
	output logic      [pr3_pkg::PIX_W-1:0]  older,
	output logic      [pr3_pkg::PIX_W-1:0]  newer
);
	import pr3_pkg::*;

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] fwd_data_q;
	logic [AW-1:0]      addr_q;
	logic               fwd_q;

	// write goes to the address of the word now leaving stage 1
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_q] <= {wr_older, wr_newer};
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= {wr_older, wr_newer};
			addr_q     <= rd_addr;
		end
	end

	// read and write of one entry at the same edge: RAM gives old data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (addr_q == rd_addr);
		end
	end

	assign {older, newer} = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

FILE: design/pr3_kernel.sv
// Stage 1 column/window logic, 3x3 binomial sum and output register.
// Depends on pr3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pr3_kernel (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire pr3_pkg::tag_t                    tag_i,
	input  wire logic [pr3_pkg::PIX_W-1:0]        px_i,
	input  wire logic [pr3_pkg::PIX_W-1:0]        older,
	input  wire logic [pr3_pkg::PIX_W-1:0]        newer,
	output logic                                  in_ready,
	output logic                                  wr_en,
	output logic      [pr3_pkg::PIX_W-1:0]        wr_older,
	output logic      [pr3_pkg::PIX_W-1:0]        wr_newer,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [pr3_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                                  m_tlast
);
	import pr3_pkg::*;

	logic             s1_valid;
	tag_t             tag_s1;
	logic [PIX_W-1:0] px_s1;
	logic             adv_out;
	logic             s1_adv;
	logic [PIX_W-1:0] ct, cm, cb;
	logic [PIX_W-1:0] lt, lm, lb, mt, mm, mb;
	logic [PIX_W-1:0] win_q [6];
	logic             emit;
	logic             done;
	logic [SUM_W-1:0] sum;

	logic                 m_tvalid_q;
	logic [SUM_W-1:0]     blurred_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic                 done_q;

	assign adv_out  = !m_tvalid_q || m_tready;
	assign s1_adv   = s1_valid && adv_out;
	assign in_ready = !s1_valid || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_i;
			px_s1  <= px_i;
		end
	end

	// vertical triple of the current column
	always_comb begin
		if (tag_s1.r_odd) begin
			cm = newer;
			ct = tag_s1.row_edge ? newer : older;
			cb = px_s1;
		end else begin
			cm = px_s1;
			ct = tag_s1.row_edge ? px_s1 : newer;
			cb = px_s1;
		end
	end

	always_comb begin
		if (tag_s1.c_odd) begin
			mt = win_q[0];
			mm = win_q[1];
			mb = win_q[2];
			lt = tag_s1.col_edge ? win_q[0] : win_q[3];
			lm = tag_s1.col_edge ? win_q[1] : win_q[4];
			lb = tag_s1.col_edge ? win_q[2] : win_q[5];
		end else begin
			mt = ct;
			mm = cm;
			mb = cb;
			lt = tag_s1.col_edge ? ct : win_q[0];
			lm = tag_s1.col_edge ? cm : win_q[1];
			lb = tag_s1.col_edge ? cb : win_q[2];
		end
	end

	assign sum = (SUM_W'(mm) << 2)
		+ ((SUM_W'(lm) + SUM_W'(cm) + SUM_W'(mt) + SUM_W'(mb)) << 1)
		+ SUM_W'(lt) + SUM_W'(ct) + SUM_W'(lb) + SUM_W'(cb);

	assign emit = (tag_s1.r_odd || tag_s1.last_row) && (tag_s1.c_odd || tag_s1.last_col);
	assign done = tag_s1.last_row && tag_s1.last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= ct;
			win_q[1] <= cm;
			win_q[2] <= cb;
		end
	end

	assign wr_en    = s1_adv;
	assign wr_older = newer;
	assign wr_newer = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_out) begin
			m_tvalid_q <= s1_adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			blurred_q <= sum;
			out_col_q <= tag_s1.out_col;
			out_row_q <= tag_s1.out_row;
			done_q    <= done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_row_q, out_col_q, blurred_q};
	assign m_tlast  = done_q;

	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> in_ready)
		else $error("word taken while stage 1 blocked");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !adv_out) |=> s1_valid && $stable(px_s1) && $stable(tag_s1))
		else $error("stalled stage 1 lost its word");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(s1_valid))
		else $error("result without a word in stage 1");
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (32'(blurred_q) <= SUM_MAX))
		else $error("weighted sum out of range");

endmodule
`default_nettype wire

FILE: verif/tb_pyramid_reduce_3x3_core.sv
// Self-checking testbench for pyramid_reduce_3x3_core: streams raster frames and
// predicts every half-size blurred word and its coordinates and frame-end mark.
// Depends on pr3_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_pyramid_reduce_3x3_core;
	import pr3_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int RAND_WORDS  = 270;
	localparam int RAND_CALM   = 200;

	typedef struct packed {
		logic [SUM_W-1:0]     blurred;
		logic [OUT_COL_W-1:0] out_col;
		logic [OUT_ROW_W-1:0] out_row;
		logic                 frame_done;
	} blur_word_t;

	class blur_scoreboard;
		int unsigned width_reg;
		int unsigned height_reg;
		logic [7:0]  older_row [MAX_WIDTH_DEF];
		logic [7:0]  newer_row [MAX_WIDTH_DEF];
		logic [7:0]  win [6];
		int unsigned col;
		int unsigned row;
		blur_word_t  expected_blur [$];
		int          errors;

		function new();
			width_reg  = FRAME_W_RST;
			height_reg = FRAME_H_RST;
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col    = 0;
			row    = 0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: begin
					width_reg = data[FRAME_W_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_reg = data[FRAME_H_W-1:0];
				end
				default: begin
					return;
				end
			endcase
			col = 0;
			row = 0;
		endfunction

		function void take_pixel(logic [7:0] px);
			int unsigned w, h, lt, lm, lb, mt, mm, mb, rt, rm, rb;
			logic [7:0]  ct, cm, cb;
			bit          row_ok, col_ok, last_row, last_col;
			blur_word_t  res;
			w = (width_reg == 0) ? 1 :
				((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
			h = (height_reg == 0) ? 1 :
				((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
			last_row = (row + 1 >= h);
			last_col = (col + 1 >= w);
			if (row[0]) begin
				cm     = newer_row[col];
				ct     = (row >= 2) ? older_row[col] : cm;
				cb     = px;
				row_ok = 1'b1;
			end else begin
				cm     = px;
				ct     = (row >= 1) ? newer_row[col] : px;
				cb     = px;
				row_ok = last_row;
			end
			col_ok = col[0] || last_col;
			if (row_ok && col_ok) begin
				if (col[0]) begin
					mt = win[0];
					mm = win[1];
					mb = win[2];
					if (col >= 2) begin
						lt = win[3];
						lm = win[4];
						lb = win[5];
					end else begin
						lt = mt;
						lm = mm;
						lb = mb;
					end
				end else begin
					mt = ct;
					mm = cm;
					mb = cb;
					if (col >= 1) begin
						lt = win[0];
						lm = win[1];
						lb = win[2];
					end else begin
						lt = mt;
						lm = mm;
						lb = mb;
					end
				end
				rt = ct;
				rm = cm;
				rb = cb;
				res.blurred    = SUM_W'(4 * mm + 2 * (lm + rm + mt + mb) + lt + rt + lb + rb);
				res.out_col    = OUT_COL_W'(col >> 1);
				res.out_row    = OUT_ROW_W'(row >> 1);
				res.frame_done = last_row && last_col;
				expected_blur.push_back(res);
			end
			win[3] = win[0];
			win[4] = win[1];
			win[5] = win[2];
			win[0] = ct;
			win[1] = cm;
			win[2] = cb;
			older_row[col] = newer_row[col];
			newer_row[col] = px;
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void check_word(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
			blur_word_t exp_w;
			if (expected_blur.size() == 0) begin
				$error("unexpected result word: tdata %h tlast %b", tdata, tlast);
				errors++;
				return;
			end
			exp_w = expected_blur.pop_front();
			if (tdata[SUM_W-1:0] !== exp_w.blurred) begin
				$error("blurred: expected %0d, actual %0d", exp_w.blurred, tdata[SUM_W-1:0]);
				errors++;
			end
			if (tdata[SUM_W +: OUT_COL_W] !== exp_w.out_col) begin
				$error("out_col: expected %0d, actual %0d", exp_w.out_col,
					tdata[SUM_W +: OUT_COL_W]);
				errors++;
			end
			if (tdata[SUM_W + OUT_COL_W +: OUT_ROW_W] !== exp_w.out_row) begin
				$error("out_row: expected %0d, actual %0d", exp_w.out_row,
					tdata[SUM_W + OUT_COL_W +: OUT_ROW_W]);
				errors++;
			end
			if (tlast !== exp_w.frame_done) begin
				$error("frame_done: expected %0d, actual %0d", exp_w.frame_done, tlast);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata  = '0;    // [7:0] pixel
	logic                   m_tvalid;
	logic                   m_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_tdata;          // [11:0] blurred, [20:12] out_col, [31:21] out_row
	logic                   m_tlast;          // frame_done
	logic                   cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	blur_scoreboard sb;
	bit             tx_idle = 1'b1;
	bit             rx_idle = 1'b1;
	bit             long_hold_done = 1'b0;
	int unsigned    words_in = 0;
	int unsigned    quiet_cycles = 0;

	pyramid_reduce_3x3_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// handshake monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_reg_t'(cfg_idx), cfg_data);
			if (s_tvalid && s_tready) begin
				sb.take_pixel(s_tdata);
				words_in++;
			end
			if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$error("no word moved for %0d cycles", quiet_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// result sink: random back-pressure plus one long hold mid-stream
	initial begin
		forever begin
			@(posedge clk);
			if (!long_hold_done && words_in >= 300) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				m_tready <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input logic [7:0] px);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.expected_blur.size() != 0);
	endtask

	// only while idle; any write restarts the frame
	task automatic program_regs(input bit wr_w, input bit wr_h,
		input logic [CFG_DATA_W-1:0] w_data, input logic [CFG_DATA_W-1:0] h_data);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (wr_w) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= REG_FRAME_WIDTH;
			cfg_data <= w_data;
			@(posedge clk);
		end
		if (wr_h) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= REG_FRAME_HEIGHT;
			cfg_data <= h_data;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned w, h, n, nfr, sel, mode, rand_words;
		bit          first_round;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as 1x1: each pixel is a whole frame
		program_regs(1'b1, 1'b1, 13'd0, 13'd0);
		send_pixel(8'hff);
		send_pixel(8'h00);
		program_regs(1'b1, 1'b1, 13'd3, 13'd3);
		for (int i = 0; i < 9; i++) send_pixel(i[0] ? 8'h00 : 8'hff);
		program_regs(1'b1, 1'b1, 13'd2, 13'd2);
		send_pixel(8'h00);
		send_pixel(8'hff);
		send_pixel(8'hff);
		send_pixel(8'h00);
		program_regs(1'b1, 1'b1, 13'd5, 13'd1);
		send_pixel(8'h80);
		send_pixel(8'h7f);
		send_pixel(8'h55);
		send_pixel(8'haa);
		send_pixel(8'h01);

		// width above line depth saturates; upper data bits are dropped
		program_regs(1'b1, 1'b1, 13'h17d0, 13'd1);
		repeat (1024) send_pixel(8'($urandom_range(0, 255)));
		// height above 4096 saturates; one column, cut short by the next write
		program_regs(1'b1, 1'b1, 13'd1, 13'd8191);
		for (int i = 0; i < 40; i++) begin
			if (i == 20) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			send_pixel(8'($urandom_range(0, 255)));
		end

		rand_words  = 0;
		first_round = 1'b1;
		w           = 1;
		h           = 1;
		while (rand_words < RAND_WORDS) begin
			tx_idle = (rand_words < RAND_CALM) && ($urandom_range(0, 3) != 0);
			rx_idle = (rand_words < RAND_CALM) && ($urandom_range(0, 3) != 0);
			sel     = first_round ? 2 : $urandom_range(0, 3);
			if (sel != 1) w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) :
				$urandom_range(1, 12);
			if (sel != 0) h = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) :
				$urandom_range(1, 9);
			program_regs(sel != 1, sel != 0,
				{2'($urandom_range(0, 3)), 11'(w)}, 13'(h));
			first_round = 1'b0;
			mode = $urandom_range(0, 3);
			nfr  = $urandom_range(1, 3);
			for (int f = 0; f < nfr; f++) begin
				n = w * h;
				// broken frame: cut short, next write restarts it
				if (f == nfr - 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n);
				for (int k = 0; k < n && rand_words < RAND_WORDS; k++) begin
					if (mode == 0) send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
					else send_pixel(8'($urandom_range(0, 255)));
					rand_words++;
				end
			end
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.expected_blur.size() != 0) begin
			$error("%0d expected words never arrived", sb.expected_blur.size());
			sb.errors++;
		end
		if (sb.errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

FILE: pyramid_reduce_3x3_core.f
design/pr3_pkg.sv
design/pr3_pos.sv
design/pr3_linebuf.sv
design/pr3_kernel.sv
design/pyramid_reduce_3x3_core.sv
verif/tb_pyramid_reduce_3x3_core.sv
